/* rtl/core/tfnm_pkg.sv */
package tfnm_pkg;
   localparam int DefBucketBits     = 10;
   localparam int DefOverflowFactor = 5;
   localparam int DefVertexBits     = 20;
   localparam int DefTetBits        = 20;
   localparam int CfgBits           = 4;
   localparam int MinTableBits      = 4;
   localparam int OutTetBits        = 20;

   // face record handed from the front end to the table walker
   typedef struct packed {
      logic [DefTetBits-1:0]    tet;
      logic [1:0]               face;
      logic [DefVertexBits-1:0] v0;
      logic [DefVertexBits-1:0] v1;
      logic [DefVertexBits-1:0] v2;
   } face_type;
endpackage

/* rtl/core/tfnm_front.sv */
module tfnm_front #(
   parameter int TetBits    = tfnm_pkg::DefTetBits,
   parameter int VertexBits = tfnm_pkg::DefVertexBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [TetBits-1:0]    in_tet,
   input  logic [VertexBits-1:0] in_va,
   input  logic [VertexBits-1:0] in_vb,
   input  logic [VertexBits-1:0] in_vc,
   input  logic [VertexBits-1:0] in_vd,
   output logic                  fc_valid,
   input  logic                  fc_ready,
   output logic [TetBits-1:0]    fc_tet,
   output logic [1:0]            fc_face,
   output logic [VertexBits-1:0] fc_v0,
   output logic [VertexBits-1:0] fc_v1,
   output logic [VertexBits-1:0] fc_v2
);
   logic                  busy_ff, busy_in;
   logic [1:0]            face_ff, face_in;
   logic [TetBits-1:0]    tet_ff, tet_in;
   logic [VertexBits-1:0] c_ff [4];
   logic [VertexBits-1:0] c_in [4];
   logic [VertexBits-1:0] a, b, c, x0, x1, y1, y2, z0;

   assign in_ready = !busy_ff;
   assign fc_valid = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      face_in = face_ff;
      tet_in  = tet_ff;
      c_in    = c_ff;
      if (in_valid && in_ready) begin
         busy_in = 1'b1;
         face_in = 2'd0;
         tet_in  = in_tet;
         c_in[0] = in_va;
         c_in[1] = in_vb;
         c_in[2] = in_vc;
         c_in[3] = in_vd;
      end else if (busy_ff && fc_ready) begin
         face_in = face_ff + 2'd1;
         if (face_ff == 2'd3) busy_in = 1'b0;
      end
   end

   // pick the three corners opposite the current one, then sort
   always_comb begin
      unique case (face_ff)
         2'd0: begin a = c_ff[1]; b = c_ff[2]; c = c_ff[3]; end
         2'd1: begin a = c_ff[0]; b = c_ff[2]; c = c_ff[3]; end
         2'd2: begin a = c_ff[0]; b = c_ff[1]; c = c_ff[3]; end
         default: begin a = c_ff[0]; b = c_ff[1]; c = c_ff[2]; end
      endcase
      x0 = (a > b) ? b : a;
      x1 = (a > b) ? a : b;
      y1 = (x1 > c) ? c : x1;
      y2 = (x1 > c) ? x1 : c;
      z0 = (x0 > y1) ? y1 : x0;
      fc_v1 = (x0 > y1) ? x0 : y1;
      fc_v0 = z0;
      fc_v2 = y2;
   end
   assign fc_tet  = tet_ff;
   assign fc_face = face_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         face_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         face_ff <= face_in;
      end
      tet_ff <= tet_in;
      c_ff   <= c_in;
   end
endmodule

/* rtl/core/tfnm_queue.sv */
module tfnm_queue #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [Width-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] slot_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = slot_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wp_ff] <= wr_data;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("lost push");
endmodule

/* rtl/core/tfnm_back.sv */
module tfnm_back #(
   parameter int BucketBits     = tfnm_pkg::DefBucketBits,
   parameter int OverflowFactor = tfnm_pkg::DefOverflowFactor,
   parameter int TetBits        = tfnm_pkg::DefTetBits,
   parameter int VertexBits     = tfnm_pkg::DefVertexBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_we,
   input  logic [tfnm_pkg::CfgBits-1:0]  cfg_data,
   input  logic                          fc_valid,
   output logic                          fc_ready,
   input  logic [TetBits-1:0]            fc_tet,
   input  logic [1:0]                    fc_face,
   input  logic [VertexBits-1:0]         fc_v0,
   input  logic [VertexBits-1:0]         fc_v1,
   input  logic [VertexBits-1:0]         fc_v2,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tfnm_pkg::OutTetBits-1:0] out_this_tet,
   output logic [1:0]                    out_face,
   output logic                          out_matched,
   output logic [tfnm_pkg::OutTetBits-1:0] out_ntet,
   output logic [1:0]                    out_nface,
   output logic                          out_full,
   output logic                          out_last
);
   import tfnm_pkg::*;
   localparam int Depth = OverflowFactor << BucketBits;
   localparam int AddrBits = $clog2(Depth + 1);
   localparam int HashBits = VertexBits + 6;
   localparam int DataBits = 1 + AddrBits + TetBits + 2 + 3 * VertexBits;
   localparam logic [AddrBits-1:0] DepthA = AddrBits'(Depth);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_HASH = 7'b0000100,
      S_READ  = 7'b0001000, S_CHECK = 7'b0010000, S_WRITE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type            st_ff, st_in;
   logic [CfgBits-1:0]   tb_ff;
   logic [AddrBits-1:0]  clr_ff, ovf_ff, addr_ff, wr_addr_ff, link_addr_ff;
   logic [AddrBits-1:0]  steps_ff;
   logic [HashBits-1:0]  hash_ff;
   logic [TetBits-1:0]   tet_ff;
   logic [1:0]           face_ff;
   logic [VertexBits-1:0] v0_ff, v1_ff, v2_ff;
   logic                 link_upd_ff;
   logic                 o_valid_ff, o_match_ff, o_full_ff;
   logic [TetBits-1:0]   o_ntet_ff;
   logic [1:0]           o_nface_ff;
   logic [DataBits-1:0]  mem [Depth];
   logic [DataBits-1:0]  rd_ff;
   logic                 mem_we;
   logic [AddrBits-1:0]  mem_wa;
   logic [DataBits-1:0]  mem_wd;
   logic                 e_valid;
   logic [AddrBits-1:0]  e_link;
   logic [TetBits-1:0]   e_tet;
   logic [1:0]           e_face;
   logic [VertexBits-1:0] e_v0, e_v1, e_v2;
   logic [CfgBits-1:0]   tb_clamped;

   assign {e_valid, e_link, e_tet, e_face, e_v0, e_v1, e_v2} = rd_ff;
   assign tb_clamped = (cfg_data < CfgBits'(MinTableBits)) ? CfgBits'(MinTableBits) :
                       (int'(cfg_data) > BucketBits) ? CfgBits'(BucketBits) : cfg_data;

   assign fc_ready  = (st_ff == S_IDLE) && !o_valid_ff && !cfg_we;
   assign out_valid = o_valid_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = '0;
      if (st_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (st_ff == S_WRITE) begin
         mem_we = 1'b1;
         mem_wa = wr_addr_ff;
         mem_wd = {1'b1, AddrBits'(0), tet_ff, face_ff, v0_ff, v1_ff, v2_ff};
      end else if (st_ff == S_OUT && link_upd_ff) begin
         // link the old chain tail to the new entry
         mem_we = 1'b1;
         mem_wa = link_addr_ff;
         mem_wd = {e_valid, wr_addr_ff, e_tet, e_face, e_v0, e_v1, e_v2};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa[AddrBits-1:0] < DepthA ? mem_wa : '0] <= mem_wd;
      rd_ff <= mem[addr_ff < DepthA ? addr_ff : '0];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_CLEAR: if (clr_ff == DepthA - AddrBits'(1)) st_in = S_IDLE;
         S_IDLE:  if (fc_valid && fc_ready) st_in = S_HASH;
         S_HASH:  st_in = S_READ;
         S_READ:  st_in = S_CHECK;
         S_CHECK: st_in = S_OUT;
         S_WRITE: st_in = S_OUT;
         S_OUT:   st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_CLEAR;
         tb_ff      <= CfgBits'(BucketBits < 10 ? BucketBits : 10);
         clr_ff     <= '0;
         ovf_ff     <= AddrBits'(1) << (BucketBits < 10 ? BucketBits : 10);
         o_valid_ff <= 1'b0;
         link_upd_ff <= 1'b0;
      end else if (cfg_we) begin
         tb_ff  <= tb_clamped;
         ovf_ff <= AddrBits'(1) << tb_clamped;
         clr_ff <= '0;
         st_ff  <= S_CLEAR;
      end else begin
         if (o_valid_ff && out_ready) o_valid_ff <= 1'b0;
         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AddrBits'(1);
               st_ff  <= st_in;
            end
            S_IDLE: begin
               link_upd_ff <= 1'b0;
               if (fc_valid && fc_ready) begin
                  tet_ff <= fc_tet; face_ff <= fc_face;
                  v0_ff <= fc_v0; v1_ff <= fc_v1; v2_ff <= fc_v2;
                  hash_ff <= HashBits'(fc_v0) * HashBits'(31)
                           + HashBits'(fc_v1) * HashBits'(7)
                           + HashBits'(fc_v2) * HashBits'(3);
               end
               st_ff <= st_in;
            end
            S_HASH: begin
               addr_ff  <= AddrBits'(hash_ff & ((HashBits'(1) << tb_ff) - HashBits'(1)));
               steps_ff <= '0;
               st_ff    <= st_in;
            end
            S_READ: st_ff <= st_in;
            S_CHECK: begin
               o_match_ff <= 1'b0; o_full_ff <= 1'b0;
               o_ntet_ff  <= '0;   o_nface_ff <= '0;
               if (!e_valid && steps_ff == '0) begin
                  wr_addr_ff <= addr_ff;
                  st_ff <= S_WRITE;
               end else if (e_valid && e_v0 == v0_ff && e_v1 == v1_ff && e_v2 == v2_ff) begin
                  o_match_ff <= 1'b1; o_ntet_ff <= e_tet; o_nface_ff <= e_face;
                  st_ff <= S_OUT;
               end else if (e_link != '0 && e_link < DepthA && steps_ff < DepthA - AddrBits'(1)) begin
                  addr_ff  <= e_link;
                  steps_ff <= steps_ff + AddrBits'(1);
                  st_ff    <= S_READ;
               end else if (steps_ff >= DepthA - AddrBits'(1) && e_link != '0 && e_link < DepthA) begin
                  st_ff <= S_OUT;
               end else if (ovf_ff >= DepthA) begin
                  o_full_ff <= 1'b1;
                  st_ff <= S_OUT;
               end else begin
                  wr_addr_ff   <= ovf_ff;
                  link_addr_ff <= addr_ff;
                  link_upd_ff  <= 1'b1;
                  ovf_ff       <= ovf_ff + AddrBits'(1);
                  st_ff        <= S_WRITE;
               end
            end
            S_WRITE: st_ff <= S_OUT;
            S_OUT: begin
               o_valid_ff <= 1'b1;
               st_ff <= st_in;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign out_this_tet = OutTetBits'(tet_ff);
   assign out_face     = face_ff;
   assign out_matched  = o_match_ff;
   assign out_ntet     = OutTetBits'(o_ntet_ff);
   assign out_nface    = o_nface_ff;
   assign out_full     = o_full_ff;
   assign out_last     = face_ff == 2'd3;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_matched) |-> !out_full)
      else $error("match and full together");
   assert property (@(posedge clock) disable iff (reset) (st_ff == S_CLEAR) |-> !fc_ready)
      else $error("accepted during clear");
   assert property (@(posedge clock) disable iff (reset) (ovf_ff <= DepthA))
      else $error("overflow pointer past end");
endmodule

/* rtl/core/tet_face_neighbour_matcher.sv */
// Face matcher for tetrahedra: takes one tetrahedron word, gives four result
// words (faces 0..3, tlast on face 3). The table walk handles one face at a
// time and takes the next face only once the last result has been taken; a
// face that is stored takes longer than one that matches, and every extra
// chain step in the table memory adds a read and a check. After reset and
// after every csr write the table is swept clear, one entry a cycle, over all
// OVERFLOW_FACTOR * 2^BUCKET_BITS entries (5120 by default); one tetrahedron
// word may be taken meanwhile, but its faces wait until the sweep ends.
module tet_face_neighbour_matcher #(
   parameter int BUCKET_BITS     = tfnm_pkg::DefBucketBits,
   parameter int OVERFLOW_FACTOR = tfnm_pkg::DefOverflowFactor
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata,      // table_bits
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,      // tet_index, vert_a, vert_b, vert_c, vert_d
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,      // this_tet, face_number, neighbour_tet,
                                        // neighbour_face, zero fill
   output logic [1:0]   rsp_tuser,      // matched, table_full
   output logic         rsp_tlast
);
   import tfnm_pkg::*;
   localparam int FaceBits = $bits(face_type);

   logic [19:0] f_tet; logic [1:0] f_face;
   logic [19:0] f_v0, f_v1, f_v2;
   logic f_valid, f_ready, b_valid, b_ready;
   face_type qin, qout;
   logic [19:0] o_tet, o_ntet; logic [1:0] o_face, o_nface;
   logic o_match, o_full;

   tfnm_front #(.TetBits(20), .VertexBits(20)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_tet(req_tdata[19:0]), .in_va(req_tdata[39:20]), .in_vb(req_tdata[59:40]),
      .in_vc(req_tdata[79:60]), .in_vd(req_tdata[99:80]),
      .fc_valid(f_valid), .fc_ready(f_ready), .fc_tet(f_tet), .fc_face(f_face),
      .fc_v0(f_v0), .fc_v1(f_v1), .fc_v2(f_v2));

   assign qin = '{tet: f_tet, face: f_face, v0: f_v0, v1: f_v1, v2: f_v2};

   tfnm_queue #(.Width(FaceBits)) u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(qin),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(qout));

   tfnm_back #(.BucketBits(BUCKET_BITS), .OverflowFactor(OVERFLOW_FACTOR),
               .TetBits(20), .VertexBits(20)) u_back (
      .clock, .reset, .cfg_we(csr_we), .cfg_data(csr_wdata),
      .fc_valid(b_valid), .fc_ready(b_ready), .fc_tet(qout.tet), .fc_face(qout.face),
      .fc_v0(qout.v0), .fc_v1(qout.v1), .fc_v2(qout.v2),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_this_tet(o_tet),
      .out_face(o_face), .out_matched(o_match), .out_ntet(o_ntet),
      .out_nface(o_nface), .out_full(o_full), .out_last(rsp_tlast));

   assign rsp_tdata = {4'd0, o_nface, o_ntet, o_face, o_tet};
   assign rsp_tuser = {o_full, o_match};
endmodule

/* sim/testbench.sv */
module testbench;
   import tfnm_pkg::*;

   localparam int Depth = DefOverflowFactor << DefBucketBits;
   localparam int Half  = 6;

   typedef struct {
      logic [19:0] tet;
      logic [19:0] v [4];
   } tet_word_type;

   typedef struct packed {
      logic [19:0] this_tet;
      logic [1:0]  face_number;
      logic        matched;
      logic [19:0] neighbour_tet;
      logic [1:0]  neighbour_face;
      logic        table_full;
      logic        last;
   } face_result_type;

   class face_scoreboard;
      int unsigned  tbits;
      bit           slot_used [Depth];
      logic [19:0]  slot_tet [Depth];
      logic [1:0]   slot_face [Depth];
      logic [19:0]  slot_vert [Depth][3];
      int unsigned  slot_next [Depth];
      int unsigned  spill_free;
      face_result_type awaited [$];
      int           mismatches;
      int           checked;
      int           matches_seen;
      int           full_seen;

      function void set_bits(logic [3:0] value);
         tbits = (value < MinTableBits) ? MinTableBits :
                 (value > DefBucketBits) ? DefBucketBits : value;
         for (int i = 0; i < Depth; i++) begin
            slot_used[i] = 0;
            slot_next[i] = 0;
         end
         spill_free = 1 << tbits;
      endfunction

      // work out the four face results of one accepted tetrahedron word
      function void note(tet_word_type w);
         logic [19:0]  s [3];
         logic [19:0]  t;
         logic [63:0]  key;
         int unsigned  e, nx, k;
         face_result_type r;
         bit           hit;
         for (int j = 0; j < 4; j++) begin
            k = 0;
            for (int i = 0; i < 4; i++) if (i != j) begin
               s[k] = w.v[i];
               k++;
            end
            if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
            if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
            if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
            key = 64'd31 * s[0] + 64'd7 * s[1] + 64'd3 * s[2];
            e = 32'(key & ((64'd1 << tbits) - 64'd1));
            r = '{w.tet, j[1:0], 1'b0, 20'd0, 2'd0, 1'b0, j == 3};
            if (!slot_used[e]) begin
               store(e, w.tet, j[1:0], s);
            end else begin
               for (int steps = 0; steps < Depth; steps++) begin
                  hit = slot_used[e] && slot_vert[e][0] == s[0] &&
                        slot_vert[e][1] == s[1] && slot_vert[e][2] == s[2];
                  if (hit) begin
                     r.matched = 1;
                     r.neighbour_tet = slot_tet[e];
                     r.neighbour_face = slot_face[e];
                     break;
                  end
                  nx = slot_next[e];
                  if (nx != 0 && nx < Depth) begin
                     e = nx;
                     continue;
                  end
                  if (spill_free >= Depth) begin
                     r.table_full = 1;
                  end else begin
                     slot_next[e] = spill_free;
                     store(spill_free, w.tet, j[1:0], s);
                     spill_free++;
                  end
                  break;
               end
            end
            awaited.push_back(r);
         end
      endfunction

      function void store(int unsigned e, logic [19:0] tet, logic [1:0] f,
                          logic [19:0] s [3]);
         slot_used[e] = 1;
         slot_tet[e] = tet;
         slot_face[e] = f;
         for (int i = 0; i < 3; i++) slot_vert[e][i] = s[i];
         slot_next[e] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check(face_result_type got);
         face_result_type exp;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result tet %0d face %0d", got.this_tet,
                             got.face_number));
            return;
         end
         exp = awaited.pop_front();
         checked++;
         if (got.matched) matches_seen++;
         if (got.table_full) full_seen++;
         if (got !== exp)
            report($sformatf({"tet %0d face %0d: got m%0b n%0d/%0d f%0b l%0b, ",
                              "want tet %0d face %0d m%0b n%0d/%0d f%0b l%0b"},
               got.this_tet, got.face_number, got.matched, got.neighbour_tet,
               got.neighbour_face, got.table_full, got.last, exp.this_tet,
               exp.face_number, exp.matched, exp.neighbour_tet, exp.neighbour_face,
               exp.table_full, exp.last));
      endtask
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_we = 0;
   logic [3:0]   csr_wdata = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [47:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   face_scoreboard board = new;
   bit             calm = 0;
   int             items_sent = 0;

   tet_face_neighbour_matcher dut (.*);

   always #Half clock = ~clock;

   task send_word(tet_word_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, w.v[3], w.v[2], w.v[1], w.v[0], w.tet};
      do @(posedge clock); while (!req_tready);
      board.note(w);
      items_sent++;
      @(negedge clock);
   endtask

   task send_tet(logic [19:0] tet, logic [19:0] a, logic [19:0] b,
                 logic [19:0] c, logic [19:0] d);
      tet_word_type w;
      w.tet = tet;
      w.v[0] = a;
      w.v[1] = b;
      w.v[2] = c;
      w.v[3] = d;
      send_word(w);
   endtask

   // drain, then write the table size while the block is idle
   task set_table_bits(logic [3:0] value);
      req_tvalid <= 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      board.set_bits(value);
      @(negedge clock);
      csr_we <= 0;
   endtask

   // mostly mesh-like: vertices from a small window so faces recur
   task random_tets(int count, int window);
      tet_word_type w;
      logic [19:0]  base;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
         base = 20'($urandom_range(0, 20'hFFFFF - window));
         w.tet = (n % 17 == 5) ? 20'($urandom) : 20'($urandom_range(1, 20'hFFFFF));
         for (int i = 0; i < 4; i++)
            w.v[i] = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                 : 20'(base + $urandom_range(0, window));
         send_word(w);
      end
      calm = 0;
   endtask

   always @(negedge clock) begin
      if (calm || $urandom_range(0, 4) == 0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 4) == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check('{rsp_tdata[19:0], rsp_tdata[21:20], rsp_tuser[0],
                       rsp_tdata[41:22], rsp_tdata[43:42], rsp_tuser[1], rsp_tlast});
   end

   initial begin
      tet_word_type w;
      board.set_bits(4'd10);
      repeat (8) @(negedge clock);
      reset <= 0;

      // directed: extremes, shared faces, repeat match, degenerate, tet zero
      send_tet(20'd1, 20'd0, 20'd1, 20'd2, 20'd3);
      send_tet(20'hFFFFF, 20'd0, 20'd1, 20'd2, 20'd4);
      send_tet(20'd2, 20'd4, 20'd2, 20'd1, 20'd0);
      send_tet(20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_tet(20'd3, 20'hFFFFF, 20'hFFFFE, 20'hFFFFF, 20'hFFFFF);
      send_tet(20'd0, 20'd3, 20'd2, 20'd1, 20'd5);
      send_tet(20'h55555, 20'hAAAAA, 20'h55555, 20'h0F0F0, 20'hF0F0F);
      send_tet(20'hAAAAA, 20'h55555, 20'hAAAAA, 20'hF0F0F, 20'h0F0F0);
      send_tet(20'd9, 20'h55555, 20'hAAAAA, 20'h0F0F0, 20'h12345);
      random_tets(60, 12);

      set_table_bits(4'd4);
      send_tet(20'd7, 20'd16, 20'd32, 20'd48, 20'd64);
      send_tet(20'd8, 20'd32, 20'd48, 20'd64, 20'd80);
      random_tets(70, 10);
      set_table_bits(4'd0);
      random_tets(50, 8);
      set_table_bits(4'd15);
      random_tets(60, 20);
      set_table_bits(4'd7);
      random_tets(60, 14);
      set_table_bits(4'd3);
      random_tets(40, 6);

      // scatter unrelated faces over the full-size table
      set_table_bits(4'd10);
      for (int n = 0; n < 60; n++) begin
         w.tet = 20'($urandom_range(1, 20'hFFFFF));
         for (int i = 0; i < 4; i++) w.v[i] = 20'($urandom);
         send_word(w);
      end
      send_tet(20'd11, 20'd0, 20'd1, 20'd2, 20'd3);

      req_tvalid <= 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("sent %0d tetrahedra over seven table size settings, checked %0d faces",
               items_sent, board.checked);
      $display("%0d faces matched, %0d refused on a full table",
               board.matches_seen, board.full_seen);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #(12 * 1500000);
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
   end
endmodule
